// File: sv/rrc_pkg.sv
// Package for the RAM range coalescer: payload structs, register indexes,
// reset values and widths. Used by every module of the block but rrc_queue.
`timescale 1ns / 1ps

package rrc_pkg;

  localparam int ADDR_W = 64;
  localparam int TYPE_W = 3;
  localparam int TYPE_COUNT = 1 << TYPE_W;
  localparam int CFG_INDEX_W = 1;
  localparam int PAGE_BITS_DEFAULT = 12;
  localparam int JOB_DEPTH_DEFAULT = 4;
  localparam int RESULT_DEPTH_DEFAULT = 2;

  localparam logic [ADDR_W-1:0] MAX_ADDRESS_RESET = '1;
  localparam logic [TYPE_COUNT-1:0] ACCEPTED_TYPES_RESET = TYPE_COUNT'(97);

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPTED_TYPES = 1'b1;

  localparam logic ACTION_ENTRY = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef struct packed {
    logic              action;
    logic [TYPE_W-1:0] entry_type;
    logic [ADDR_W-1:0] entry_base;
    logic [ADDR_W-1:0] entry_length;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] region_head;
    logic [ADDR_W-1:0] region_tail;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     max_address;
    logic [TYPE_COUNT-1:0] accepted_types;
  } cfg_t;

  // Classified entry handed from the front part to the back part.
  typedef struct packed {
    logic              flush;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] tail;
  } job_t;

endpackage

// File: sv/rrc_queue.sv
// Small first-in first-out queue for the RAM range coalescer.
// Generic over the item type; uses no package.
`timescale 1ns / 1ps

module rrc_queue #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     push_data,
  output logic push_ready,
  input  logic pop,
  output T     pop_data,
  output logic pop_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign pop_valid  = (count != '0);
  assign do_pop     = pop && pop_valid;
  assign push_ready = (count != CNT_W'(DEPTH)) || do_pop;
  assign do_push    = push && push_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/rrc_front.sv
// Front part of the RAM range coalescer: accepts requests, drops rejected
// entries and computes each entry's clamped last address. Uses rrc_pkg.
`timescale 1ns / 1ps

module rrc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrc_pkg::in_item_t in_item,
  output logic             full,
  input  rrc_pkg::cfg_t    cfg,
  output logic             job_valid,
  output rrc_pkg::job_t    job,
  input  logic             job_ready
);
  import rrc_pkg::*;

  logic              stage_valid;
  job_t              stage;
  logic              accept;
  logic              keep;
  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] sat_tail;
  logic [ADDR_W-1:0] clamp_tail;

  assign full      = stage_valid && !job_ready;
  assign accept    = push && !full;
  assign job_valid = stage_valid;
  assign job       = stage;

  always_comb begin
    sum        = {1'b0, in_item.entry_base} + {1'b0, in_item.entry_length} - (ADDR_W + 1)'(1);
    sat_tail   = sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
    clamp_tail = (sat_tail > cfg.max_address) ? cfg.max_address : sat_tail;
    keep       = (in_item.action == ACTION_FLUSH) ||
                 (cfg.accepted_types[in_item.entry_type] && (in_item.entry_length != '0));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.flush <= (in_item.action == ACTION_FLUSH);
      stage.base  <= in_item.entry_base;
      stage.tail  <= clamp_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= keep;
    end else if (stage_valid && job_ready) begin
      stage_valid <= 1'b0;
    end
  end

endmodule

// File: sv/rrc_back.sv
// Back part of the RAM range coalescer: merges entries into the pending
// region and shrinks closed regions to whole pages. Uses rrc_pkg.
`timescale 1ns / 1ps

module rrc_back #(
  parameter int PAGE_BITS = rrc_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  rrc_pkg::job_t               job,
  output logic                        job_take,
  input  logic [rrc_pkg::ADDR_W-1:0]  max_address,
  output logic                        result_valid,
  output rrc_pkg::out_item_t          result,
  input  logic                        result_ready
);
  import rrc_pkg::*;

  localparam logic [ADDR_W-1:0] OFFSET_MASK = (ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1);

  logic [ADDR_W-1:0] pending_head;
  logic [ADDR_W-1:0] pending_tail;
  logic              pending_valid;

  logic [ADDR_W:0]   head_sum;
  logic [ADDR_W-1:0] round_head;
  logic [ADDR_W-1:0] trim_raw;
  logic [ADDR_W-1:0] trim_tail;
  logic              shrink_ok;
  logic              gap;
  logic              close;

  always_comb begin
    head_sum     = {1'b0, pending_head} + {1'b0, OFFSET_MASK};
    round_head   = head_sum[ADDR_W-1:0] & ~OFFSET_MASK;
    trim_raw     = (pending_tail - OFFSET_MASK) | OFFSET_MASK;
    trim_tail    = (trim_raw > max_address) ? max_address : trim_raw;
    shrink_ok    = !head_sum[ADDR_W] && (pending_tail >= OFFSET_MASK) &&
                   (trim_tail >= round_head);
    gap          = ({1'b0, pending_tail} + (ADDR_W + 1)'(1)) < {1'b0, job.base};
    close        = pending_valid && (job.flush || gap);
    job_take     = job_valid && result_ready;
    result_valid = job_take && close && shrink_ok;
    result.region_head = round_head;
    result.region_tail = trim_tail;
  end

  always_ff @(posedge clk) begin
    if (job_take && !job.flush) begin
      if (pending_valid && !gap) begin
        if (pending_tail < job.tail) begin
          pending_tail <= job.tail;
        end
      end else begin
        pending_head <= job.base;
        pending_tail <= job.tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
    end else if (job_take) begin
      pending_valid <= !job.flush;
    end
  end

endmodule

// File: sv/ram_range_coalescer.sv
// Top level of the RAM range coalescer: configuration registers, front
// part, job queue, back part and result queue. Uses rrc_pkg.
`timescale 1ns / 1ps

// The block takes one memory-map request per cycle and keeps that rate as
// long as results are popped. A request passes a classify register, a job
// queue and the merge logic before its result is written into the result
// queue, from which a closed region appears on the result ports. The
// sustained rate is set by the merge step, which updates the single pending
// region once per cycle while the result queue has room. Configuration
// writes are always ready and take effect on the next cycle; change them
// only while the block is idle.
module ram_range_coalescer #(
  parameter int PAGE_BITS = rrc_pkg::PAGE_BITS_DEFAULT,
  parameter int JOB_DEPTH = rrc_pkg::JOB_DEPTH_DEFAULT,
  parameter int RESULT_DEPTH = rrc_pkg::RESULT_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  rrc_pkg::in_item_t                   in_item,
  output logic                                empty,
  input  logic                                pop,
  output rrc_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rrc_pkg::ADDR_W-1:0]          cfg_data
);
  import rrc_pkg::*;

  cfg_t      cfg;
  logic      front_valid;
  job_t      front_job;
  logic      front_ready;
  logic      job_valid;
  job_t      job;
  logic      job_take;
  logic      result_valid;
  out_item_t result;
  logic      result_ready;
  logic      out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_address    <= MAX_ADDRESS_RESET;
      cfg.accepted_types <= ACCEPTED_TYPES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_ADDRESS:    cfg.max_address    <= cfg_data;
        CFG_ACCEPTED_TYPES: cfg.accepted_types <= cfg_data[TYPE_COUNT-1:0];
        default: ;
      endcase
    end
  end

  rrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cfg       (cfg),
    .job_valid (front_valid),
    .job       (front_job),
    .job_ready (front_ready)
  );

  rrc_queue #(
    .T     (job_t),
    .DEPTH (JOB_DEPTH)
  ) u_job_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_data  (front_job),
    .push_ready (front_ready),
    .pop        (job_take),
    .pop_data   (job),
    .pop_valid  (job_valid)
  );

  rrc_back #(
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job),
    .job_take     (job_take),
    .max_address  (cfg.max_address),
    .result_valid (result_valid),
    .result       (result),
    .result_ready (result_ready)
  );

  rrc_queue #(
    .T     (out_item_t),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (result_valid),
    .push_data  (result),
    .push_ready (result_ready),
    .pop        (pop),
    .pop_data   (out_item),
    .pop_valid  (out_valid)
  );

endmodule
